### design/baro_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared widths, calibration register indexes, pipeline stage counts and the
// structs that carry an item between the pipeline sections.
// ----------------------------------------------------------------------------
package baro_pkg;

  // Field widths.
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 17;
  localparam int CFG_A_W = 3;

  // Working widths of the intermediates.
  localparam int DT_W   = 25;
  localparam int TC_W   = 15;  // clamped first-order temperature
  localparam int OFF_W  = 35;
  localparam int SENS_W = 34;
  localparam int T2_W   = 18;

  // Calibration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_SENS_BASE   = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_OFF_BASE    = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_SENS_TEMPCO = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_OFF_TEMPCO  = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_REF_TEMP    = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_TEMP_SLOPE  = 3'd5;

  // Pipeline depth per section.
  localparam int FRONT_STAGES = 3;
  localparam int CORR_STAGES  = 2;
  localparam int PRESS_STAGES = 5;
  localparam int NUM_STAGES   = FRONT_STAGES + CORR_STAGES + PRESS_STAGES;

  // Calibration words.
  typedef struct packed {
    logic [CAL_W-1:0] sens_base;
    logic [CAL_W-1:0] off_base;
    logic [CAL_W-1:0] sens_tempco;
    logic [CAL_W-1:0] off_tempco;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_slope;
  } cal_t;

  // First-order results.
  typedef struct packed {
    logic signed [TC_W-1:0]   temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic [T2_W-1:0]          t2;
    logic [RAW_W-1:0]         d1;
  } front_t;

  // Second-order corrected results.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic [RAW_W-1:0]         d1;
  } corr_t;

endpackage

### design/baro_ctrl.sv
// ----------------------------------------------------------------------------
// Pipeline flow control
// Per-stage valid bits and a ready chain, so bubbles are squeezed out and a
// stall at the output holds each occupied stage with no empty stage after it.
// ----------------------------------------------------------------------------
module baro_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [baro_pkg::NUM_STAGES-1:0] en
);
  import baro_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] rdy;

  // A stage can load when it is empty or when the stage after it loads.
  always_comb begin
    rdy[NUM_STAGES-1] = ~vld_r[NUM_STAGES-1] | out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  // Valid bits move with the data.
  always_comb begin
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end else begin
      vld_nxt[0] = vld_r[0];
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en        = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

### design/baro_front.sv
// ----------------------------------------------------------------------------
// First-order compensation
// Three stages: dT, the four dT products, then TEMP, OFF, SENS and the T2
// term with truncating divisions and the temperature clamp.
// ----------------------------------------------------------------------------
module baro_front (
  input  logic                                clk,
  input  logic [baro_pkg::FRONT_STAGES-1:0]   en,
  input  baro_pkg::cal_t                      cal,
  input  logic [baro_pkg::RAW_W-1:0]          raw_pressure,
  input  logic [baro_pkg::RAW_W-1:0]          raw_temperature,
  output baro_pkg::front_t                    front
);
  import baro_pkg::*;

  // Stage 1: dT = D2 - C5 * 256.
  logic signed [DT_W-1:0] dt_nxt, dt_r;
  logic [RAW_W-1:0]       d1_s1_r;

  assign dt_nxt = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ref_temp, 8'h00});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt_r    <= dt_nxt;
      d1_s1_r <= raw_pressure;
    end
  end

  // Stage 2: products of dT with C6, C4, C3 and with itself.
  logic signed [41:0] p6_nxt, p4_nxt, p3_nxt, p6_r, p4_r, p3_r;
  logic signed [49:0] pdd_nxt, pdd_r;
  logic [RAW_W-1:0]   d1_s2_r;

  assign p6_nxt  = dt_r * $signed({1'b0, cal.temp_slope});
  assign p4_nxt  = dt_r * $signed({1'b0, cal.off_tempco});
  assign p3_nxt  = dt_r * $signed({1'b0, cal.sens_tempco});
  assign pdd_nxt = dt_r * dt_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p6_r    <= p6_nxt;
      p4_r    <= p4_nxt;
      p3_r    <= p3_nxt;
      pdd_r   <= pdd_nxt;
      d1_s2_r <= d1_s1_r;
    end
  end

  // Stage 3: divisions truncate toward zero by biasing negative values.
  front_t front_nxt, front_r;

  always_comb begin
    logic signed [41:0] q6;
    logic signed [41:0] q4;
    logic signed [41:0] q3;
    logic signed [19:0] temp_raw;
    logic signed [41:0] off_w;
    logic signed [41:0] sens_w;
    q6 = (p6_r + (p6_r[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
    q4 = (p4_r + (p4_r[41] ? 42'sd127 : 42'sd0)) >>> 7;
    q3 = (p3_r + (p3_r[41] ? 42'sd255 : 42'sd0)) >>> 8;
    temp_raw = $signed(q6[19:0]) + 20'sd2000;
    off_w  = $signed({10'b0, cal.off_base, 16'h0000}) + q4;
    sens_w = $signed({11'b0, cal.sens_base, 15'h0000}) + q3;
    if (temp_raw < -20'sd4000) begin
      front_nxt.temp = -15'sd4000;
    end else if (temp_raw > 20'sd8500) begin
      front_nxt.temp = 15'sd8500;
    end else begin
      front_nxt.temp = temp_raw[TC_W-1:0];
    end
    front_nxt.off  = off_w[OFF_W-1:0];
    front_nxt.sens = sens_w[SENS_W-1:0];
    front_nxt.t2   = pdd_r[48:31];
    front_nxt.d1   = d1_s2_r;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

endmodule

### design/baro_corr.sv
// ----------------------------------------------------------------------------
// Second-order correction
// Two stages: the squared distances from 20 C and -15 C, then the T2, OFF2
// and SENS2 corrections applied below those thresholds.
// ----------------------------------------------------------------------------
module baro_corr (
  input  logic                              clk,
  input  logic [baro_pkg::CORR_STAGES-1:0]  en,
  input  baro_pkg::front_t                  front,
  output baro_pkg::corr_t                   corr
);
  import baro_pkg::*;

  // Stage 4: squares and threshold flags.
  logic signed [TC_W-1:0] dlo, dhi;
  logic signed [29:0]     sq_full, sq2_full;
  logic [25:0]            sq_r;
  logic [22:0]            sq2_r;
  logic                   lt_r, lt15_r;
  front_t                 front_s4_r;

  assign dlo      = front.temp - 15'sd2000;
  assign dhi      = front.temp + 15'sd1500;
  assign sq_full  = dlo * dlo;
  assign sq2_full = dhi * dhi;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_r       <= sq_full[25:0];
      sq2_r      <= sq2_full[22:0];
      lt_r       <= (front.temp < 15'sd2000);
      lt15_r     <= (front.temp < -15'sd1500);
      front_s4_r <= front;
    end
  end

  // Stage 5: constant multiples by shift-add, then subtract the corrections.
  corr_t corr_nxt, corr_r;

  always_comb begin
    logic [28:0] five_sq;
    logic [28:0] seven_sq2;
    logic [28:0] eleven_sq2;
    logic [28:0] off2;
    logic [28:0] sens2;
    logic [T2_W-1:0] t2;
    five_sq    = {1'b0, sq_r, 2'b00} + {3'b000, sq_r};
    seven_sq2  = {3'b000, sq2_r, 3'b000} - {6'b000000, sq2_r};
    eleven_sq2 = {3'b000, sq2_r, 3'b000} + {5'b00000, sq2_r, 1'b0} + {6'b000000, sq2_r};
    off2  = '0;
    sens2 = '0;
    t2    = '0;
    if (lt_r) begin
      t2    = front_s4_r.t2;
      off2  = {1'b0, five_sq[28:1]};
      sens2 = {2'b00, five_sq[28:2]};
      if (lt15_r) begin
        off2  = off2 + seven_sq2;
        sens2 = sens2 + {1'b0, eleven_sq2[28:1]};
      end
    end
    corr_nxt.temp = $signed({{(TEMP_W-TC_W){front_s4_r.temp[TC_W-1]}}, front_s4_r.temp})
                    - $signed({1'b0, t2});
    corr_nxt.off  = front_s4_r.off - $signed({6'b000000, off2});
    corr_nxt.sens = front_s4_r.sens - $signed({5'b00000, sens2});
    corr_nxt.d1   = front_s4_r.d1;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      corr_r <= corr_nxt;
    end
  end

  assign corr = corr_r;

endmodule

### design/baro_press.sv
// ----------------------------------------------------------------------------
// Pressure calculation
// Five stages: split D1 * SENS into two partial products, combine them,
// divide by 2^21, subtract OFF, divide by 2^15 and clamp to 1000..120000.
// ----------------------------------------------------------------------------
module baro_press (
  input  logic                               clk,
  input  logic [baro_pkg::PRESS_STAGES-1:0]  en,
  input  baro_pkg::corr_t                    corr,
  output logic signed [baro_pkg::TEMP_W-1:0] temp_centideg,
  output logic [baro_pkg::PRES_W-1:0]        pressure_pa
);
  import baro_pkg::*;

  // Stage 6: partial products on the low and high halves of SENS.
  logic [40:0]              pp_lo_nxt, pp_lo_r;
  logic signed [41:0]       pp_hi_nxt, pp_hi_r;
  logic signed [OFF_W-1:0]  off_s6_r, off_s7_r, off_s8_r;
  logic signed [TEMP_W-1:0] temp_s6_r, temp_s7_r, temp_s8_r, temp_s9_r, temp_s10_r;

  assign pp_lo_nxt = {17'b0, corr.d1} * {24'b0, corr.sens[16:0]};
  assign pp_hi_nxt = $signed({1'b0, corr.d1}) * $signed(corr.sens[SENS_W-1:17]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_lo_r   <= pp_lo_nxt;
      pp_hi_r   <= pp_hi_nxt;
      off_s6_r  <= corr.off;
      temp_s6_r <= corr.temp;
    end
  end

  // Stage 7: full product D1 * SENS.
  logic signed [58:0] full_nxt, full_r;

  assign full_nxt = $signed({pp_hi_r, 17'h00000}) + $signed({18'b0, pp_lo_r});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      full_r    <= full_nxt;
      off_s7_r  <= off_s6_r;
      temp_s7_r <= temp_s6_r;
    end
  end

  // Stage 8: truncating divide by 2^21.
  logic signed [58:0] full_sh;
  logic signed [37:0] q_r;

  assign full_sh = (full_r + (full_r[58] ? 59'sd2097151 : 59'sd0)) >>> 21;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q_r       <= full_sh[37:0];
      off_s8_r  <= off_s7_r;
      temp_s8_r <= temp_s7_r;
    end
  end

  // Stage 9: subtract the offset.
  logic signed [37:0] x_nxt, x_r;

  assign x_nxt = q_r - $signed({{(38-OFF_W){off_s8_r[OFF_W-1]}}, off_s8_r});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x_r       <= x_nxt;
      temp_s9_r <= temp_s8_r;
    end
  end

  // Stage 10: truncating divide by 2^15 and clamp; this is the output register.
  logic signed [37:0]     x_sh;
  logic signed [22:0]     y;
  logic [PRES_W-1:0]      p_nxt, p_r;

  assign x_sh = (x_r + (x_r[37] ? 38'sd32767 : 38'sd0)) >>> 15;
  assign y    = x_sh[22:0];

  always_comb begin
    if (y < 23'sd1000) begin
      p_nxt = 17'd1000;
    end else if (y > 23'sd120000) begin
      p_nxt = 17'd120000;
    end else begin
      p_nxt = y[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p_r        <= p_nxt;
      temp_s10_r <= temp_s9_r;
    end
  end

  assign temp_centideg = temp_s10_r;
  assign pressure_pa   = p_r;

endmodule

### design/baro_pressure_temp_compensation.sv
// Throughput: one conversion pair per cycle; each stage holds while the one
// after it is full and stalled, and empty stages fill behind a stall.
// Reset (rst_n low, synchronous) empties the pipeline and clears all six
// calibration words to zero.
// ----------------------------------------------------------------------------
// Barometric pressure and temperature compensation
// Ten-stage pipeline turning raw D1/D2 conversions into temperature in
// hundredths of a degree and pressure in pascals, with second-order terms.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [baro_pkg::CFG_A_W-1:0]         cfg_addr,
  input  logic [baro_pkg::CAL_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [baro_pkg::RAW_W-1:0]           in_raw_pressure,
  input  logic [baro_pkg::RAW_W-1:0]           in_raw_temperature,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [baro_pkg::TEMP_W-1:0]   out_temp_centideg,
  output logic [baro_pkg::PRES_W-1:0]          out_pressure_pa
);
  import baro_pkg::*;

  // Calibration registers; writes to unused indexes are dropped.
  cal_t cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SENS_BASE:   cal_r.sens_base   <= cfg_wdata;
        CFG_OFF_BASE:    cal_r.off_base    <= cfg_wdata;
        CFG_SENS_TEMPCO: cal_r.sens_tempco <= cfg_wdata;
        CFG_OFF_TEMPCO:  cal_r.off_tempco  <= cfg_wdata;
        CFG_REF_TEMP:    cal_r.ref_temp    <= cfg_wdata;
        CFG_TEMP_SLOPE:  cal_r.temp_slope  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Flow control for all stages.
  logic [NUM_STAGES-1:0] en;

  baro_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .en        (en)
  );

  // Datapath sections.
  front_t front;
  corr_t  corr;

  baro_front u_front (
    .clk             (clk),
    .en              (en[FRONT_STAGES-1:0]),
    .cal             (cal_r),
    .raw_pressure    (in_raw_pressure),
    .raw_temperature (in_raw_temperature),
    .front           (front)
  );

  baro_corr u_corr (
    .clk   (clk),
    .en    (en[FRONT_STAGES+CORR_STAGES-1:FRONT_STAGES]),
    .front (front),
    .corr  (corr)
  );

  baro_press u_press (
    .clk           (clk),
    .en            (en[NUM_STAGES-1:FRONT_STAGES+CORR_STAGES]),
    .corr          (corr),
    .temp_centideg (out_temp_centideg),
    .pressure_pa   (out_pressure_pa)
  );

endmodule
